>>> rtl/tppc_pkg.sv
// ----------------------------------------------------------------------------
// tppc_pkg: shared constants for the triac phase PID controller
// Field widths, register indexes, reset values and output scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tppc_pkg;

  // Width of the arithmetic on speeds and of the integral accumulator
  localparam int SPEED_BITS    = 16;
  localparam int INTEGRAL_BITS = 48;

  // Field widths of the channels
  localparam int SPEED_W    = 16;
  localparam int PHASE_W    = 8;
  localparam int SYNC_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register widths
  localparam int GAIN_W = 16;
  localparam int IV_W   = 16;
  localparam int LIM_W  = 16;
  localparam int BIAS_W = 8;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_IV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_BIAS = 3'd5;

  // Register reset values
  localparam int GAIN_P_RST = 256;
  localparam int GAIN_I_RST = 0;
  localparam int GAIN_D_RST = 0;
  localparam int TICK_IV_RST = 6554;
  localparam int INT_LIMIT_RST = 12800;
  localparam int PHASE_BIAS_RST = 130;

  // Fixed-point alignment of the PID terms (sum is in Q.16 degrees)
  localparam int FRAC_BITS = 16;
  localparam int P_SHIFT   = 8;
  localparam int I_SHIFT   = 8;
  localparam int D_SHIFT   = 24;
  localparam int LIM_SHIFT = 16;

  // Phase range and sync scaling: sync = 1000 - floor(deg * 1000 / 180),
  // with deg*1000/180 taken as (deg * 364100) >> 16, exact for deg <= 180
  localparam int PHASE_MAX   = 180;
  localparam int SYNC_FULL   = 1000;
  localparam int SYNC_RECIP  = 364100;
  localparam int SYNC_SHIFT  = 16;
  localparam int SYNC_PROD_W = 27;

endpackage

`default_nettype wire

>>> rtl/tppc_in_if.sv
// ----------------------------------------------------------------------------
// tppc_in_if: speed sample channel
// Carries one target / measured speed pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tppc_in_if;
  import tppc_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_target;
  logic [SPEED_W-1:0] speed_measured;

  modport source (output valid, output speed_target, output speed_measured, input ready);
  modport sink   (input valid, input speed_target, input speed_measured, output ready);
endinterface

`default_nettype wire

>>> rtl/tppc_out_if.sv
// ----------------------------------------------------------------------------
// tppc_out_if: firing phase result channel
// Carries the phase, the timer sync value and the saturation flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tppc_out_if;
  import tppc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase_degrees;
  logic [SYNC_W-1:0]  sync_delay;
  logic               phase_saturated;

  modport source (output valid, output phase_degrees, output sync_delay,
                  output phase_saturated, input ready);
  modport sink   (input valid, input phase_degrees, input sync_delay,
                  input phase_saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/tppc_cfg_if.sv
// ----------------------------------------------------------------------------
// tppc_cfg_if: register write channel
// Carries one register index and its write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tppc_cfg_if;
  import tppc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/triac_phase_pid_controller.sv
// ----------------------------------------------------------------------------
// triac_phase_pid_controller: PID speed loop producing a triac firing phase
// One speed sample beat in, one phase / sync / saturation beat out.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one beat per control tick, target and measured speed in rpm.
//   out_chan : one beat per input beat: phase in whole degrees (0..180), the
//              timer sync value 1000 - phase*1000/180 and a flag that is set
//              when the phase had to be clamped to 0 or 180.
//   cfg_chan : register writes (gains, tick interval, integral limit, bias);
//              always ready, write only while no sample is in flight.
// Timing: a sample is worked bit-serially under one step counter. The result
//   beat is loaded into the output register from the finish step once the
//   counter ends, and the next input beat is taken only after that, so no new
//   sample is accepted while one is in flight. The 57-step restoring divider
//   for the derivative term sets the length of an item; the three 16-step shift-add
//   multipliers, the 32-step clamp divider and the 16-step integral-term multiplier run underneath it.
// Stall: the result sits in an output register; if it is still not taken
//   when the next one finishes, the block holds in its finish step.
// Reset: registers go to their reset values, integral and last error clear.
// ----------------------------------------------------------------------------
`default_nettype none

module triac_phase_pid_controller (
  input  logic              clk,
  input  logic              rst_n,
  tppc_in_if.sink           in_chan,
  tppc_out_if.source        out_chan,
  tppc_cfg_if.sink          cfg_chan
);
  import tppc_pkg::*;

  // Datapath widths
  localparam int ERR_W  = SPEED_BITS + 1;       // signed error
  localparam int DIFF_W = SPEED_BITS + 2;       // signed error change
  localparam int EMAG_W = SPEED_BITS;           // |error|
  localparam int DMAG_W = SPEED_BITS + 1;       // |error change|
  localparam int P1_W   = EMAG_W + IV_W;        // |error| * interval
  localparam int P2_W   = EMAG_W + GAIN_W;      // |kp * error|
  localparam int P4_W   = DMAG_W + GAIN_W;      // |kd * diff|
  localparam int IMAG_W = INTEGRAL_BITS - 1;    // |integral|
  localparam int P3_W   = IMAG_W + GAIN_W;      // |ki * integral|
  localparam int QL_W   = LIM_W + LIM_SHIFT;    // clamp dividend
  localparam int QD_W   = P4_W + D_SHIFT;       // derivative dividend
  localparam int ACC_W  = INTEGRAL_BITS + 2;    // integral update width
  localparam int TOT_W  = QD_W + 3;             // term sum width
  localparam int HI_W   = TOT_W - 1 - FRAC_BITS;

  // Step schedule (counter values within one item)
  localparam int T_ACC     = GAIN_W;                  // products done
  localparam int T_CLAMP   = QL_W;                    // clamp quotient done
  localparam int T_M3_LOAD = T_CLAMP + 1;
  localparam int T_M3_END  = T_M3_LOAD + 1 + GAIN_W;  // integral term done
  localparam int T_D2_END  = T_ACC + 1 + QD_W;        // derivative done
  localparam int CNT_W     = $clog2(T_D2_END + 1);

  localparam logic [CNT_W-1:0] C_ACC     = CNT_W'(T_ACC);
  localparam logic [CNT_W-1:0] C_CLAMP   = CNT_W'(T_CLAMP);
  localparam logic [CNT_W-1:0] C_M3_LOAD = CNT_W'(T_M3_LOAD);
  localparam logic [CNT_W-1:0] C_M3_END  = CNT_W'(T_M3_END);
  localparam logic [CNT_W-1:0] C_D2_END  = CNT_W'(T_D2_END);

  localparam logic signed [ACC_W-1:0] IMAX =
    {{(ACC_W-IMAG_W){1'b0}}, {IMAG_W{1'b1}}};
  localparam logic signed [TOT_W-1:0] ONE_DEG =
    {{(TOT_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;

  function automatic logic [GAIN_W-1:0] gain_mag(input logic signed [GAIN_W-1:0] g);
    gain_mag = g[GAIN_W-1] ? GAIN_W'(-g) : GAIN_W'(g);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [IV_W-1:0]          ivl_r;
  logic [LIM_W-1:0]         lim_r;
  logic [BIAS_W-1:0]        bias_r;
  logic                     cfg_acc;

  assign cfg_chan.ready = 1'b1;
  assign cfg_acc        = cfg_chan.valid & cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= GAIN_W'(GAIN_P_RST);
      gain_i_r <= GAIN_W'(GAIN_I_RST);
      gain_d_r <= GAIN_W'(GAIN_D_RST);
      ivl_r    <= IV_W'(TICK_IV_RST);
      lim_r    <= LIM_W'(INT_LIMIT_RST);
      bias_r   <= BIAS_W'(PHASE_BIAS_RST);
    end else if (cfg_acc) begin
      case (cfg_chan.index)
        REG_GAIN_P:     gain_p_r <= cfg_chan.data;
        REG_GAIN_I:     gain_i_r <= cfg_chan.data;
        REG_GAIN_D:     gain_d_r <= cfg_chan.data;
        REG_TICK_IV:    ivl_r    <= cfg_chan.data;
        REG_INT_LIMIT:  lim_r    <= cfg_chan.data;
        REG_PHASE_BIAS: bias_r   <= cfg_chan.data[BIAS_W-1:0];
        default: ;  // unmapped index: drop the beat
      endcase
    end
  end

  // A zero interval counts as one
  logic [IV_W-1:0]   iv_eff;
  logic [GAIN_W-1:0] kp_mag, ki_mag, kd_mag;
  logic              ki_zero;

  assign iv_eff  = (ivl_r == '0) ? IV_W'(1) : ivl_r;
  assign kp_mag  = gain_mag(gain_p_r);
  assign ki_mag  = gain_mag(gain_i_r);
  assign kd_mag  = gain_mag(gain_d_r);
  assign ki_zero = (gain_i_r == '0);

  // --------------------------------------------------------------------------
  // Sequencer state and handshakes
  // --------------------------------------------------------------------------
  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               in_acc;
  logic               out_free;

  logic               out_valid_r;
  logic [PHASE_W-1:0] out_deg_r;
  logic [SYNC_W-1:0]  out_sync_r;
  logic               out_sat_r;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign out_free      = ~out_valid_r | out_chan.ready;

  assign out_chan.valid           = out_valid_r;
  assign out_chan.phase_degrees   = out_deg_r;
  assign out_chan.sync_delay      = out_sync_r;
  assign out_chan.phase_saturated = out_sat_r;

  // --------------------------------------------------------------------------
  // Error and error change, formed as the sample is accepted
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [ERR_W-1:0]  err_w;
  logic signed [DIFF_W-1:0] diff_w;
  logic [EMAG_W-1:0]        err_mag;
  logic [DMAG_W-1:0]        diff_mag;

  assign err_w    = signed'({1'b0, in_chan.speed_target[SPEED_BITS-1:0]})
                  - signed'({1'b0, in_chan.speed_measured[SPEED_BITS-1:0]});
  assign diff_w   = DIFF_W'(err_w) - DIFF_W'(prev_err_r);
  assign err_mag  = err_w[ERR_W-1] ? EMAG_W'(-err_w) : EMAG_W'(err_w);
  assign diff_mag = diff_w[DIFF_W-1] ? DMAG_W'(-diff_w) : DMAG_W'(diff_w);

  // --------------------------------------------------------------------------
  // Bit-serial multipliers: one multiplier bit per step, product shifts right
  // --------------------------------------------------------------------------
  logic [EMAG_W-1:0] ea_r;
  logic [DMAG_W-1:0] da_r;
  logic [IMAG_W-1:0] ia_r;
  logic [P1_W-1:0]   p1_r, p1_nxt;
  logic [P2_W-1:0]   p2_r, p2_nxt;
  logic [P4_W-1:0]   p4_r, p4_nxt;
  logic [P3_W-1:0]   p3_r, p3_nxt;
  logic [EMAG_W:0]   p1_sum, p2_sum;
  logic [DMAG_W:0]   p4_sum;
  logic [IMAG_W:0]   p3_sum;
  logic              s1_r, s2_r, s3_r, s4_r;

  assign p1_sum = {1'b0, p1_r[P1_W-1:IV_W]}   + (p1_r[0] ? {1'b0, ea_r} : '0);
  assign p2_sum = {1'b0, p2_r[P2_W-1:GAIN_W]} + (p2_r[0] ? {1'b0, ea_r} : '0);
  assign p4_sum = {1'b0, p4_r[P4_W-1:GAIN_W]} + (p4_r[0] ? {1'b0, da_r} : '0);
  assign p3_sum = {1'b0, p3_r[P3_W-1:GAIN_W]} + (p3_r[0] ? {1'b0, ia_r} : '0);
  assign p1_nxt = {p1_sum, p1_r[IV_W-1:1]};
  assign p2_nxt = {p2_sum, p2_r[GAIN_W-1:1]};
  assign p4_nxt = {p4_sum, p4_r[GAIN_W-1:1]};
  assign p3_nxt = {p3_sum, p3_r[GAIN_W-1:1]};

  // --------------------------------------------------------------------------
  // Restoring dividers: one quotient bit per step
  //   d1: integral clamp bound (limit << 16) / |ki|
  //   d2: derivative magnitude (|kd*diff| << 24) / interval
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] d1_rem_r, d1_rem_nxt;
  logic [QL_W-1:0]   d1_q_r, d1_q_nxt;
  logic [GAIN_W:0]   d1_trial, d1_sub;
  logic              d1_ge;
  logic [IV_W-1:0]   d2_rem_r, d2_rem_nxt;
  logic [QD_W-1:0]   d2_q_r, d2_q_nxt;
  logic [IV_W:0]     d2_trial, d2_sub;
  logic              d2_ge;

  assign d1_trial   = {d1_rem_r, d1_q_r[QL_W-1]};
  assign d1_sub     = d1_trial - {1'b0, ki_mag};
  assign d1_ge      = (d1_trial >= {1'b0, ki_mag});
  assign d1_rem_nxt = d1_ge ? d1_sub[GAIN_W-1:0] : d1_trial[GAIN_W-1:0];
  assign d1_q_nxt   = {d1_q_r[QL_W-2:0], d1_ge};

  assign d2_trial   = {d2_rem_r, d2_q_r[QD_W-1]};
  assign d2_sub     = d2_trial - {1'b0, iv_eff};
  assign d2_ge      = (d2_trial >= {1'b0, iv_eff});
  assign d2_rem_nxt = d2_ge ? d2_sub[IV_W-1:0] : d2_trial[IV_W-1:0];
  assign d2_q_nxt   = {d2_q_r[QD_W-2:0], d2_ge};

  // --------------------------------------------------------------------------
  // Integral update: saturating add, then symmetric clamp to the bound
  // --------------------------------------------------------------------------
  logic signed [INTEGRAL_BITS-1:0] integ_r;
  logic signed [ACC_W-1:0]         integ_ext, inc_ext, inc_s, integ_sum, integ_sat;
  logic signed [ACC_W-1:0]         q_ext, integ_clamp;
  logic [IMAG_W-1:0]               integ_mag;

  assign integ_ext = {{(ACC_W-INTEGRAL_BITS){integ_r[INTEGRAL_BITS-1]}}, integ_r};
  assign inc_ext   = {{(ACC_W-P1_W){1'b0}}, p1_r};
  assign inc_s     = s1_r ? -inc_ext : inc_ext;
  assign integ_sum = integ_ext + inc_s;
  assign integ_sat = (integ_sum > IMAX) ? IMAX :
                     (integ_sum < -IMAX) ? -IMAX : integ_sum;
  assign q_ext       = {{(ACC_W-QL_W){1'b0}}, d1_q_r};
  assign integ_clamp = (integ_ext > q_ext) ? q_ext :
                       (integ_ext < -q_ext) ? -q_ext : integ_ext;
  assign integ_mag   = integ_r[INTEGRAL_BITS-1] ? IMAG_W'(-integ_ext) : IMAG_W'(integ_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      if (in_acc) begin
        prev_err_r <= err_w;
      end
      if (state_r == ST_RUN && cnt_r == C_ACC) begin
        integ_r <= INTEGRAL_BITS'(integ_sat);
      end
      if (state_r == ST_RUN && cnt_r == C_CLAMP && !ki_zero) begin
        integ_r <= INTEGRAL_BITS'(integ_clamp);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Term sum in Q.16 degrees, built up as each term completes
  // --------------------------------------------------------------------------
  logic signed [TOT_W-1:0] acc_r;
  logic signed [TOT_W-1:0] pmag, imag, dmag, bias_q, pterm, iterm, dterm;

  assign pmag   = {{(TOT_W-P2_W-P_SHIFT){1'b0}}, p2_r, {P_SHIFT{1'b0}}};
  assign imag   = {{(TOT_W-P3_W+I_SHIFT){1'b0}}, p3_r[P3_W-1:I_SHIFT]};
  assign dmag   = {{(TOT_W-QD_W){1'b0}}, d2_q_r};
  assign bias_q = {{(TOT_W-BIAS_W-FRAC_BITS){1'b0}}, bias_r, {FRAC_BITS{1'b0}}};
  assign pterm  = s2_r ? -pmag : pmag;
  assign iterm  = s3_r ? -imag : imag;   // truncates toward zero
  assign dterm  = s4_r ? -dmag : dmag;

  // Shift registers of the serial units; no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ea_r     <= err_mag;
      da_r     <= diff_mag;
      s1_r     <= err_w[ERR_W-1];
      s2_r     <= err_w[ERR_W-1] ^ gain_p_r[GAIN_W-1];
      s4_r     <= diff_w[DIFF_W-1] ^ gain_d_r[GAIN_W-1];
      p1_r     <= {{EMAG_W{1'b0}}, iv_eff};
      p2_r     <= {{EMAG_W{1'b0}}, kp_mag};
      p4_r     <= {{DMAG_W{1'b0}}, kd_mag};
      d1_rem_r <= '0;
      d1_q_r   <= {lim_r, {LIM_SHIFT{1'b0}}};
    end else if (state_r == ST_RUN) begin
      if (cnt_r < C_ACC) begin
        p1_r <= p1_nxt;
        p2_r <= p2_nxt;
        p4_r <= p4_nxt;
      end
      if (cnt_r < C_CLAMP) begin
        d1_rem_r <= d1_rem_nxt;
        d1_q_r   <= d1_q_nxt;
      end
      if (cnt_r == C_ACC) begin
        d2_rem_r <= '0;
        d2_q_r   <= {p4_r, {D_SHIFT{1'b0}}};
        acc_r    <= pterm + bias_q;
      end
      if (cnt_r > C_ACC && cnt_r < C_D2_END) begin
        d2_rem_r <= d2_rem_nxt;
        d2_q_r   <= d2_q_nxt;
      end
      if (cnt_r == C_M3_LOAD) begin
        ia_r <= integ_mag;
        s3_r <= integ_r[INTEGRAL_BITS-1] ^ gain_i_r[GAIN_W-1];
        p3_r <= {{IMAG_W{1'b0}}, ki_mag};
      end
      if (cnt_r > C_M3_LOAD && cnt_r < C_M3_END) begin
        p3_r <= p3_nxt;
      end
      if (cnt_r == C_M3_END) begin
        acc_r <= acc_r + iterm;
      end
      if (cnt_r == C_D2_END) begin
        acc_r <= acc_r + dterm;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Whole degrees, saturation and sync value from the finished sum
  // --------------------------------------------------------------------------
  logic [HI_W-1:0]        deg_hi;
  logic [PHASE_W-1:0]     deg_nxt;
  logic                   sat_nxt;
  logic [SYNC_PROD_W-1:0] sync_prod;
  logic [SYNC_W-1:0]      sync_nxt;

  assign deg_hi = acc_r[TOT_W-2:FRAC_BITS];

  always_comb begin
    if (acc_r[TOT_W-1]) begin
      // negative sum: phase is zero; the flag is set at or below minus one degree
      deg_nxt = '0;
      sat_nxt = (acc_r <= -ONE_DEG);
    end else if (deg_hi > HI_W'(PHASE_MAX)) begin
      deg_nxt = PHASE_W'(PHASE_MAX);
      sat_nxt = 1'b1;
    end else begin
      deg_nxt = deg_hi[PHASE_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  assign sync_prod = SYNC_PROD_W'(deg_nxt) * SYNC_PROD_W'(SYNC_RECIP);
  assign sync_nxt  = SYNC_W'(SYNC_FULL) - SYNC_W'(sync_prod[SYNC_PROD_W-1:SYNC_SHIFT]);

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a finishing item reloads the output register instead
      if (out_valid_r && out_chan.ready && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == C_D2_END) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_deg_r   <= deg_nxt;
            out_sync_r  <= sync_nxt;
            out_sat_r   <= sat_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> (integ_ext <= IMAX && integ_ext >= -IMAX))
    else $error("integral outside saturation bound");

  a_clamp_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && cnt_r == C_M3_LOAD && !ki_zero
      |-> (integ_ext <= q_ext && integ_ext >= -q_ext))
    else $error("integral exceeds clamp bound after clamp step");

  a_phase_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_deg_r <= PHASE_W'(PHASE_MAX)) &&
                    (out_deg_r == '0 || out_deg_r == PHASE_W'(PHASE_MAX) || !out_sat_r))
    else $error("phase out of range or flag set inside range");

  a_sync_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_deg_r != '0 || out_sync_r == SYNC_W'(SYNC_FULL)) &&
                    (out_deg_r != PHASE_W'(PHASE_MAX) || out_sync_r == '0))
    else $error("sync value does not match phase end point");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH && out_valid_r && !out_chan.ready |=> state_r == ST_FINISH)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

>>> tb/triac_phase_pid_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triac_phase_pid_controller_tb: self-checking bench for the firing-phase PID
// Drives speed samples and register writes, predicts every phase / sync /
// saturation beat with an independent fixed-point PID model and compares.
// ----------------------------------------------------------------------------

module triac_phase_pid_controller_tb;
  import tppc_pkg::*;

  // Indexes that decode to no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam longint INTEG_MAX   = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     TAIL_CYCLES = 100;
  localparam int     REPORT_CAP  = 100;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [SPEED_W-1:0] target;
    logic [SPEED_W-1:0] measured;
  } speed_sample_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_degrees;
    logic [SYNC_W-1:0]  sync_delay;
    logic               phase_saturated;
  } firing_phase_t;

  logic clk;
  logic rst_n;

  tppc_in_if  in_chan ();
  tppc_out_if out_chan ();
  tppc_cfg_if cfg_chan ();

  triac_phase_pid_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // --------------------------------------------------------------------------
  // Controller model: register shadows and loop state
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] gain_p_r;
  logic signed [GAIN_W-1:0] gain_i_r;
  logic signed [GAIN_W-1:0] gain_d_r;
  logic [IV_W-1:0]          tick_iv_r;
  logic [LIM_W-1:0]         int_limit_r;
  logic [BIAS_W-1:0]        phase_bias_r;
  longint                   error_sum;    // integral of error * interval
  longint                   last_error;

  // Stimulus and scoreboard storage
  speed_sample_t sample_queue[$];
  firing_phase_t expected_phase_q[$];

  // Flow control knobs, set per phase
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  bit          drain_mode;     // hold each sample until the previous result is back

  int unsigned cycle_count;
  int unsigned samples_accepted;
  int unsigned phases_checked;
  int unsigned saturated_seen;
  int unsigned mismatch_count;
  int unsigned settings_used;

  // Saturate the integral to the accumulator's symmetric range.
  function automatic longint clip_integral(input longint v);
    if (v > INTEG_MAX) return INTEG_MAX;
    if (v < -INTEG_MAX) return -INTEG_MAX;
    return v;
  endfunction

  // Advance the PID loop by one tick and return the firing phase beat it yields.
  function automatic firing_phase_t predict_firing_phase(input speed_sample_t s);
    firing_phase_t     r;
    longint            kp, ki, kd, iv, lim;
    longint            err, diff, pterm, iterm, dterm, total, deg, sync;
    longint            sgn, kmag, qlim, scaled, prod;
    longint unsigned   mag, ivu, q1, r1, dmag;
    bit                sat;
    kp  = gain_p_r;
    ki  = gain_i_r;
    kd  = gain_d_r;
    iv  = longint'(tick_iv_r);
    lim = longint'(int_limit_r) <<< LIM_SHIFT;
    // A zero interval behaves as the smallest step.
    if (iv == 0) iv = 1;
    err = longint'(s.target) - longint'(s.measured);

    error_sum = clip_integral(error_sum + err * iv);
    diff = err - last_error;

    // Clamp the weighted integral to +/- limit; no clamp with zero gain.
    if (ki != 0) begin
      sgn    = (ki > 0) ? 1 : -1;
      kmag   = (ki > 0) ? ki : -ki;
      qlim   = lim / kmag;
      scaled = sgn * error_sum;
      if (scaled > qlim) error_sum = clip_integral(sgn * qlim);
      else if (scaled < -qlim) error_sum = clip_integral(-sgn * qlim);
    end

    pterm = kp * err * (longint'(1) <<< P_SHIFT);
    iterm = (ki * error_sum) / (longint'(1) <<< I_SHIFT);

    // Derivative: magnitude divided with a fractional tail, capped integer part.
    prod = kd * diff;
    if (prod < 0) mag = -prod;
    else mag = prod;
    ivu = iv;
    q1  = mag / ivu;
    r1  = mag % ivu;
    if (q1 > (64'd1 << 32)) q1 = 64'd1 << 32;
    dmag = (q1 << D_SHIFT) + ((r1 << D_SHIFT) / ivu);
    if (prod < 0) dterm = -longint'(dmag);
    else dterm = longint'(dmag);

    total = pterm + iterm + dterm + (longint'(phase_bias_r) <<< FRAC_BITS);
    deg   = total / (longint'(1) <<< FRAC_BITS);
    sat   = 1'b0;
    if (deg < 0) begin
      deg = 0;
      sat = 1'b1;
    end
    if (deg > PHASE_MAX) begin
      deg = PHASE_MAX;
      sat = 1'b1;
    end
    last_error = err;

    sync = SYNC_FULL - (deg * SYNC_FULL) / PHASE_MAX;
    r.phase_degrees   = deg[PHASE_W-1:0];
    r.sync_delay      = sync[SYNC_W-1:0];
    r.phase_saturated = sat;
    return r;
  endfunction

  // Mirror a register write into the model; unmapped indexes are dropped.
  function automatic void shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_GAIN_P:     gain_p_r     = val;
      REG_GAIN_I:     gain_i_r     = val;
      REG_GAIN_D:     gain_d_r     = val;
      REG_TICK_IV:    tick_iv_r    = val;
      REG_INT_LIMIT:  int_limit_r  = val;
      REG_PHASE_BIAS: phase_bias_r = val[BIAS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL triac_phase_pid_controller");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sample driver: present the next queued sample once the slot is free,
  // inserting random gaps and, in drain mode, waiting for the result to return.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sample_driver
    speed_sample_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (sample_queue.size() != 0 &&
          !(drain_mode && (expected_phase_q.size() != 0 || in_chan.valid)) &&
          $urandom_range(0, 99) >= in_gap_pct) begin
        nxt = sample_queue.pop_front();
        in_chan.valid          <= 1'b1;
        in_chan.speed_target   <= nxt.target;
        in_chan.speed_measured <= nxt.measured;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted sample beat, check every result beat
  // against the oldest prediction, then pick the next ready level.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : phase_monitor
    speed_sample_t taken;
    firing_phase_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        taken.target   = in_chan.speed_target;
        taken.measured = in_chan.speed_measured;
        expected_phase_q.push_back(predict_firing_phase(taken));
        samples_accepted++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_phase_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $error("result beat with no sample outstanding: phase %0d sync %0d sat %0d",
                   out_chan.phase_degrees, out_chan.sync_delay, out_chan.phase_saturated);
        end else begin
          want = expected_phase_q.pop_front();
          check_field("phase_degrees", want.phase_degrees, out_chan.phase_degrees);
          check_field("sync_delay", want.sync_delay, out_chan.sync_delay);
          check_field("phase_saturated", want.phase_saturated, out_chan.phase_saturated);
          if (want.phase_saturated) saturated_seen++;
          phases_checked++;
        end
      end
      out_chan.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Hold until no sample is queued, in flight or awaiting its result.
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || expected_phase_q.size() != 0 || in_chan.valid);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk);
    while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    shadow_reg_write(idx, val);
  endtask

  task automatic program_regs(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [IV_W-1:0] iv,
                              input logic [LIM_W-1:0] lim, input logic [BIAS_W-1:0] bias);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_TICK_IV, iv);
    write_reg(REG_INT_LIMIT, lim);
    write_reg(REG_PHASE_BIAS, {{(CFG_DATA_W-BIAS_W){1'b0}}, bias});
    settings_used++;
  endtask

  task automatic set_idle(input idle_mode_t mode, input bit drain);
    case (mode)
      IDLE_NONE:     begin in_gap_pct = 0;  out_stall_pct = 0;  end
      IDLE_SENDER:   begin in_gap_pct = 48; out_stall_pct = 0;  end
      IDLE_RECEIVER: begin in_gap_pct = 0;  out_stall_pct = 48; end
      default:       begin in_gap_pct = 18; out_stall_pct = 18; end
    endcase
    drain_mode = drain;
  endtask

  task automatic push_sample(input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] meas);
    speed_sample_t s;
    s.target   = tgt;
    s.measured = meas;
    sample_queue.push_back(s);
  endtask

  // Queue a closed-loop-like run: a base speed holds for a while and the
  // other speed of each pair hovers within +/- span of it, with some wild samples
  // and some pinned at the rails. Then hold until all of it is checked.
  task automatic queue_speed_run(input int n_items, input int span);
    int     base;
    int     roll;
    longint meas;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0 && $urandom_range(0, 1) == 1) base = $urandom_range(0, 65535);
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        meas = longint'(base) + longint'($urandom_range(0, 2 * span)) - span;
        if (meas < 0) meas = 0;
        if (meas > 65535) meas = 65535;
        if (roll < 40) push_sample(SPEED_W'(base), meas[SPEED_W-1:0]);
        else push_sample(meas[SPEED_W-1:0], SPEED_W'(base));
      end else if (roll < 92) begin
        push_sample(SPEED_W'($urandom), SPEED_W'($urandom));
      end else begin
        push_sample($urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0);
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int spans[4];
    logic [GAIN_W-1:0] kp_v, ki_v, kd_v;
    logic [IV_W-1:0]   iv_v;
    logic [LIM_W-1:0]  lim_v;
    logic [BIAS_W-1:0] bias_v;

    spans = '{2, 16, 128, 1024};

    // Drive every input to a known level before the first edge.
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.speed_target   = '0;
    in_chan.speed_measured = '0;
    out_chan.ready         = 1'b0;
    cfg_chan.valid         = 1'b0;
    cfg_chan.index         = REG_GAIN_P;
    cfg_chan.data          = '0;
    in_gap_pct       = 0;
    out_stall_pct    = 0;
    drain_mode       = 1'b0;
    cycle_count      = 0;
    samples_accepted = 0;
    phases_checked   = 0;
    saturated_seen   = 0;
    mismatch_count   = 0;
    settings_used    = 1;

    // Model starts from the register reset values with a cleared loop.
    gain_p_r     = GAIN_P_RST;
    gain_i_r     = GAIN_I_RST;
    gain_d_r     = GAIN_D_RST;
    tick_iv_r    = TICK_IV_RST;
    int_limit_r  = INT_LIMIT_RST;
    phase_bias_r = PHASE_BIAS_RST;
    error_sum    = 0;
    last_error   = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: unity P gain and 130 degree bias, so phase = error + 130.
    // Walk both rails, the exact edges of 0 and 180, and alternating bit patterns.
    set_idle(IDLE_NONE, 1'b0);
    push_sample(16'd0, 16'd0);
    push_sample(16'hFFFF, 16'd0);
    push_sample(16'd0, 16'hFFFF);
    push_sample(16'hFFFF, 16'hFFFF);
    push_sample(16'd50, 16'd0);       // lands exactly on 180
    push_sample(16'd51, 16'd0);       // one past the top
    push_sample(16'd0, 16'd130);      // lands exactly on 0
    push_sample(16'd0, 16'd131);      // one below zero
    push_sample(16'd0, 16'd129);
    push_sample(16'd1, 16'd0);
    push_sample(16'hAAAA, 16'h5555);
    push_sample(16'h5555, 16'hAAAA);
    push_sample(16'd12345, 16'd12300);
    wait_idle();

    // Moderate PID with an active integral clamp, no idling.
    program_regs(16'sd256, 16'sd512, 16'sd64, 16'd6554, 16'd12800, 8'd90);
    queue_speed_run(150, 40);

    // Most negative P and D gains, most positive I gain, shortest interval, widest limit, bias above 180.
    set_idle(IDLE_SENDER, 1'b0);
    program_regs(16'h8000, 16'h7FFF, 16'h8000, 16'd1, 16'hFFFF, 8'hFF);
    push_sample(16'hFFFF, 16'd0);     // largest error swings, derivative at its peak
    push_sample(16'd0, 16'hFFFF);
    push_sample(16'hFFFF, 16'd0);
    push_sample(16'd100, 16'd100);
    queue_speed_run(140, 1024);

    // Most positive P/D, negative I gain, longest interval, zero limit, zero bias.
    // Pause every sample until the previous result has come back.
    set_idle(IDLE_RECEIVER, 1'b1);
    program_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 8'd0);
    queue_speed_run(100, 2);

    // Zero interval and a 180 degree bias; writes to unmapped indexes must be ignored.
    set_idle(IDLE_BOTH, 1'b0);
    program_regs(16'sd1, 16'sd0, 16'sd1, 16'd0, 16'd300, 8'd180);
    write_reg(REG_UNMAPPED_LO, 16'hFFFF);
    write_reg(REG_UNMAPPED_HI, 16'h5A5A);
    queue_speed_run(150, 128);

    // Random settings, mostly small gains so the phase stays off the rails.
    for (int ph = 0; ph < 6; ph++) begin
      set_idle(idle_mode_t'(ph % 4), 1'b0);
      kp_v = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 1023) - 512)
                                          : 16'($urandom);
      ki_v = ($urandom_range(0, 99) < 20) ? 16'd0
           : ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 1023) - 512)
                                          : 16'($urandom);
      kd_v = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 1023) - 512)
                                          : 16'($urandom);
      iv_v   = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 65535))
                                           : 16'($urandom_range(1, 100));
      lim_v  = 16'($urandom);
      bias_v = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(181, 255))
                                           : 8'($urandom_range(0, 180));
      program_regs(kp_v, ki_v, kd_v, iv_v, lim_v, bias_v);
      queue_speed_run(160, spans[$urandom_range(0, 3)]);
    end

    // Let any stray result beat surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_phase_q.size() != 0) begin
      mismatch_count++;
      $error("%0d results never arrived", expected_phase_q.size());
    end

    $display("Covered %0d speed samples across %0d register settings and all idle modes;",
             samples_accepted, settings_used);
    $display("checked %0d firing-phase beats, %0d of them saturated, %0d mismatches.",
             phases_checked, saturated_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS triac_phase_pid_controller");
    end else begin
      $display("FAIL triac_phase_pid_controller");
    end
    $finish;
  end

endmodule
